// ===== sv/urxts_pkg.sv =====
// Shared types and constants for the UART receive edge timestamp decoder.
// Used by every module of the block and by its port checker; no dependencies.
`default_nettype none

package urxts_pkg;

  localparam int TIMER_BITS     = 16;
  localparam int TIME_W         = TIMER_BITS + 1;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int TRIG_W         = 5;
  localparam int COUNT_W        = 5;

  // request modes
  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_STOP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TRIGGER  = 2'd2;

  localparam logic [15:0]       BIT_PERIOD_RST  = 16'd434;
  localparam logic [15:0]       STOP_OFFSET_RST = 16'd3906;
  localparam logic [TRIG_W-1:0] RX_TRIGGER_RST  = 5'd1;

  localparam logic [3:0] LAST_SAMPLE = 4'd9;

  typedef struct packed {
    logic [1:0]            mode;
    logic [TIMER_BITS-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [TIMER_BITS-1:0] stop_time;
    logic                  stop_time_valid;
    logic [7:0]            read_data;
    logic                  read_framing_error;
    logic [COUNT_W-1:0]    fifo_count;
    logic                  overflow;
    logic                  trigger;
    logic                  busy_res;
  } out_item_t;

  // controller to datapath command
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_UNWRAP,
    OP_STOP,
    OP_READ,
    OP_NOP_EVENT,
    OP_STEP,
    OP_TOGGLE,
    OP_RESPOND
  } op_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       frame_active;
    logic       step_more;
  } dp_stat_t;

  // datapath to FIFO request
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [8:0] wr_entry;
  } fifo_req_t;

endpackage

`default_nettype wire

// ===== sv/urxts_fifo.sv =====
// Receive FIFO: entry memory, pointers, fill count and sticky overflow flag.
// Depends on urxts_pkg for the request struct.
`default_nettype none

module urxts_fifo #(
  parameter int DEPTH = urxts_pkg::FIFO_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  urxts_pkg::fifo_req_t        req,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  output logic                        full,
  output logic                        overflow,
  output logic [8:0]                  rd_entry
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [8:0]    mem [DEPTH];
  logic [8:0]    rd_entry_r;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;

  assign wp_inc = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign full   = (cnt_r == CW'(DEPTH));

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (req.wr) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        wp_nxt  = wp_inc;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (req.rd) begin
      ovf_nxt = 1'b0;
      // empty FIFO: same entry again, nothing moves
      if (cnt_r != '0) begin
        rp_nxt  = rp_inc;
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr && !full) begin
      mem[wp_inc] <= req.wr_entry;
    end
    if (req.rd) begin
      rd_entry_r <= mem[rp_nxt];
    end
  end

  assign count    = cnt_r;
  assign overflow = ovf_r;
  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

// ===== sv/urxts_dpath.sv =====
// Datapath: config registers, frame timing, bit sampling, result assembly.
// Depends on urxts_pkg and instantiates urxts_fifo.
`default_nettype none

module urxts_dpath #(
  parameter int FIFO_DEPTH = urxts_pkg::FIFO_DEPTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  urxts_pkg::op_t                        op,
  output urxts_pkg::dp_stat_t                   stat,
  input  urxts_pkg::in_item_t                   in_data,
  output urxts_pkg::out_item_t                  out_data,
  input  wire                                   cfg_wr_en,
  input  wire [urxts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [urxts_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int TB   = urxts_pkg::TIMER_BITS;
  localparam int TW   = urxts_pkg::TIME_W;
  localparam int CW   = $clog2(FIFO_DEPTH + 1);
  localparam int CMPW = (CW >= urxts_pkg::TRIG_W) ? CW + 1 : urxts_pkg::TRIG_W + 1;

  logic [15:0]                 bp_r, so_r;
  logic [urxts_pkg::TRIG_W-1:0] trig_lvl_r;
  logic [1:0]                  mode_r;
  logic [TB-1:0]               ts_r;
  logic                        active_r, active_nxt;
  logic                        line_r, line_nxt;
  logic [TW-1:0]               last_r, last_nxt, next_r, next_nxt, cur_r;
  logic [7:0]                  shift_r, shift_nxt;
  logic [3:0]                  samples_r, samples_nxt;
  logic [TB-1:0]               res_stop_r;
  logic                        res_stv_r, res_trig_r, res_read_r;
  urxts_pkg::out_item_t        out_data_r;

  logic [TW-1:0]  start_next, start_stop, ts_ext;
  logic [3:0]     bit_idx, first;
  logic [7:0]     fill_mask, stop_shift;
  logic           exec, stop_trig;
  logic [CMPW-1:0] cnt_inc;

  urxts_pkg::fifo_req_t fifo_req;
  logic [CW-1:0] fifo_count;
  logic          fifo_full, fifo_ovf;
  logic [8:0]    fifo_rd_entry;

  urxts_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (fifo_req),
    .count    (fifo_count),
    .full     (fifo_full),
    .overflow (fifo_ovf),
    .rd_entry (fifo_rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r       <= urxts_pkg::BIT_PERIOD_RST;
      so_r       <= urxts_pkg::STOP_OFFSET_RST;
      trig_lvl_r <= urxts_pkg::RX_TRIGGER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        urxts_pkg::CFG_BIT_PERIOD:  bp_r       <= cfg_data;
        urxts_pkg::CFG_STOP_OFFSET: so_r       <= cfg_data;
        urxts_pkg::CFG_RX_TRIGGER:  trig_lvl_r <= cfg_data[urxts_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  assign ts_ext     = {1'b0, ts_r};
  assign start_next = ts_ext + TW'(bp_r >> 1);
  assign start_stop = start_next + TW'(so_r);
  assign bit_idx    = samples_r - 4'd1;
  assign first      = (samples_r == 4'd0) ? 4'd0 : samples_r - 4'd1;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fill_mask[i] = (4'(i) >= first);
    end
  end

  assign stop_shift = (shift_r & ~fill_mask) | (line_r ? fill_mask : 8'h00);
  assign cnt_inc    = CMPW'(fifo_count) + 1'b1;
  assign stop_trig  = !fifo_full && (cnt_inc >= CMPW'(trig_lvl_r));
  assign exec       = (op == urxts_pkg::OP_START) || (op == urxts_pkg::OP_UNWRAP) ||
                      (op == urxts_pkg::OP_STOP) || (op == urxts_pkg::OP_READ) ||
                      (op == urxts_pkg::OP_NOP_EVENT);

  assign fifo_req.wr       = (op == urxts_pkg::OP_STOP);
  assign fifo_req.rd       = (op == urxts_pkg::OP_READ);
  assign fifo_req.wr_entry = {~line_r, stop_shift};

  always_comb begin
    active_nxt  = active_r;
    line_nxt    = line_r;
    last_nxt    = last_r;
    next_nxt    = next_r;
    shift_nxt   = shift_r;
    samples_nxt = samples_r;
    case (op)
      urxts_pkg::OP_START: begin
        active_nxt  = 1'b1;
        line_nxt    = 1'b0;
        last_nxt    = ts_ext;
        next_nxt    = start_next;
        shift_nxt   = 8'h00;
        samples_nxt = 4'd0;
      end
      urxts_pkg::OP_STEP: begin
        // sample point 0 is the start bit
        if (samples_r != 4'd0 && line_r) begin
          shift_nxt[bit_idx[2:0]] = 1'b1;
        end
        samples_nxt = samples_r + 4'd1;
        last_nxt    = last_r + TW'(bp_r);
        next_nxt    = next_r + TW'(bp_r);
      end
      urxts_pkg::OP_TOGGLE: line_nxt = ~line_r;
      urxts_pkg::OP_STOP: begin
        shift_nxt   = stop_shift;
        active_nxt  = 1'b0;
        samples_nxt = 4'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      line_r    <= 1'b0;
      last_r    <= '0;
      next_r    <= '0;
      shift_r   <= '0;
      samples_r <= '0;
    end else begin
      active_r  <= active_nxt;
      line_r    <= line_nxt;
      last_r    <= last_nxt;
      next_r    <= next_nxt;
      shift_r   <= shift_nxt;
      samples_r <= samples_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (op == urxts_pkg::OP_LOAD) begin
      mode_r <= in_data.mode;
      ts_r   <= in_data.timestamp;
    end
    if (op == urxts_pkg::OP_UNWRAP) begin
      // timer wrapped since the last edge
      cur_r <= (ts_ext < last_r) ? {1'b1, ts_r} : ts_ext;
    end
    if (exec) begin
      res_stop_r <= (op == urxts_pkg::OP_START) ? start_stop[TB-1:0] : '0;
      res_stv_r  <= (op == urxts_pkg::OP_START);
      res_trig_r <= (op == urxts_pkg::OP_STOP) && stop_trig;
      res_read_r <= (op == urxts_pkg::OP_READ);
    end
    if (op == urxts_pkg::OP_RESPOND) begin
      out_data_r.stop_time          <= res_stop_r;
      out_data_r.stop_time_valid    <= res_stv_r;
      out_data_r.read_data          <= res_read_r ? fifo_rd_entry[7:0] : 8'h00;
      out_data_r.read_framing_error <= res_read_r & fifo_rd_entry[8];
      out_data_r.fifo_count         <= urxts_pkg::COUNT_W'(fifo_count);
      out_data_r.overflow           <= fifo_ovf;
      out_data_r.trigger            <= res_trig_r;
      out_data_r.busy_res           <= active_r;
    end
  end

  assign stat.mode         = mode_r;
  assign stat.frame_active = active_r;
  assign stat.step_more    = (samples_r < urxts_pkg::LAST_SAMPLE) && (cur_r > next_r);
  assign out_data          = out_data_r;

endmodule

`default_nettype wire

// ===== sv/urxts_ctrl.sv =====
// Controller: request sequencing, sample-point iteration and output handshake.
// Depends on urxts_pkg for command and status types.
`default_nettype none

module urxts_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  urxts_pkg::dp_stat_t stat,
  output urxts_pkg::op_t      op
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_STEP = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op            = urxts_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = urxts_pkg::OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (stat.mode)
          urxts_pkg::MODE_EDGE: begin
            if (stat.frame_active) begin
              op        = urxts_pkg::OP_UNWRAP;
              state_nxt = S_STEP;
            end else begin
              op = urxts_pkg::OP_START;
            end
          end
          urxts_pkg::MODE_STOP:
            op = stat.frame_active ? urxts_pkg::OP_STOP : urxts_pkg::OP_NOP_EVENT;
          urxts_pkg::MODE_READ: op = urxts_pkg::OP_READ;
          default:              op = urxts_pkg::OP_NOP_EVENT;
        endcase
      end
      S_STEP: begin
        if (stat.step_more) begin
          op = urxts_pkg::OP_STEP;
        end else begin
          op        = urxts_pkg::OP_TOGGLE;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          op            = urxts_pkg::OP_RESPOND;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/uart_rx_edge_timestamp_decoder.sv =====
// Top level of the UART 8N1 receiver driven by timer events.
// Depends on urxts_pkg; instantiates urxts_ctrl and urxts_dpath.
//
//   channel  | direction | ports                          | moves
//   ---------+-----------+--------------------------------+------------------------------
//   in       | input     | in_valid, in_ready, in_data    | one event request
//   out      | output    | out_valid, out_ready, out_data | one result per request
//   cfg      | input     | cfg_wr_en, cfg_index, cfg_data | register write, no wait
//
// One request at a time. A start edge, stop match, host read or unused mode runs
// through the idle (accept), execute and respond states. An edge inside a frame
// also passes k (0..9) sample points, one per cycle in the step state, and then
// toggles the line level. The result register loads as the respond state ends,
// and in_ready rises at the same edge. Only a result still unaccepted in that
// register stalls the load on out_ready. Synchronous active-low reset; FIFO memory
// is not cleared.
`default_nettype none

module uart_rx_edge_timestamp_decoder #(
  parameter int FIFO_DEPTH = urxts_pkg::FIFO_DEPTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  urxts_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output urxts_pkg::out_item_t            out_data,
  input  wire                             cfg_wr_en,
  input  wire [urxts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [urxts_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command and status between controller and datapath
  urxts_pkg::op_t      op;
  urxts_pkg::dp_stat_t stat;

  urxts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  // config registers, frame timing, sampling, receive FIFO and result register
  urxts_dpath #(.FIFO_DEPTH(FIFO_DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== sv/urxts_checker.sv =====
// Port checker for uart_rx_edge_timestamp_decoder, attached by bind.
// Depends on urxts_pkg for the payload types.
`default_nettype none

module urxts_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input urxts_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  a_stop_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stop_time_valid |-> out_data.stop_time == '0)
    else $error("stop time without frame start");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stop_time_valid |-> out_data.busy_res && !out_data.trigger)
    else $error("frame start result inconsistent");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind uart_rx_edge_timestamp_decoder urxts_checker u_urxts_checker (.*);

`default_nettype wire

// ===== test/uart_rx_edge_timestamp_decoder_tb.sv =====
// Self-checking testbench for uart_rx_edge_timestamp_decoder (8N1 receive from timer events).
// Depends on urxts_pkg and the block's RTL; it has its own event decoder and FIFO
// tracker, and drives directed rows and then random frames through several settings.
module uart_rx_edge_timestamp_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urxts_pkg::*;

  // Mode 3 has no name in the package; the block does nothing for it.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int FIFO_DEPTH  = FIFO_DEPTH_DEF;
  // Longest request is an edge inside a frame that passes all nine sample
  // points. Settle time before register writes and at the end.
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 200;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int DIR_ROWS      = 24;

  // Directed row: a request and, where it is obvious, the result typed in.
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  uart_rx_edge_timestamp_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Decoder state mirror: registers, frame in progress and the receive FIFO.
  // ---------------------------------------------------------------------------
  logic [15:0]       bit_ticks   = BIT_PERIOD_RST;
  logic [15:0]       stop_ticks  = STOP_OFFSET_RST;
  logic [TRIG_W-1:0] trig_level  = RX_TRIGGER_RST;

  logic              in_frame     = 1'b0;
  logic              line_hi      = 1'b0;
  logic [TIME_W-1:0] prev_edge    = '0;
  logic [TIME_W-1:0] sample_at    = '0;
  logic [7:0]        frame_bits   = '0;
  logic [3:0]        points_seen  = '0;
  logic [8:0]        rx_fifo [FIFO_DEPTH];
  bit                fifo_filled [FIFO_DEPTH];
  logic [3:0]        wr_ptr       = '0;
  logic [3:0]        rd_ptr       = '0;
  logic [COUNT_W-1:0] fifo_level  = '0;
  logic              overrun      = 1'b0;

  out_item_t pending_results[$];

  int sent           = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int bytes_stored   = 0;
  int bytes_dropped  = 0;
  int cfg_settings   = 1;
  int holds_done     = 0;
  int tx_streak      = 0;
  bit hold_off_req   = 1'b0;

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    for (int i = 0; i < FIFO_DEPTH; i++) fifo_filled[i] = 1'b0;
  end

  // Apply one event to the mirror and return the result the block must give.
  function automatic out_item_t decode_event(in_item_t req);
    out_item_t         r;
    logic [TIME_W-1:0] cur;
    logic [8:0]        entry;
    int                first;
    int                i;
    r = '0;
    case (req.mode)
      MODE_EDGE: begin
        if (!in_frame) begin
          // idle edge is always a start bit: first sample half a bit later
          prev_edge   = {1'b0, req.timestamp};
          sample_at   = prev_edge + TIME_W'(bit_ticks >> 1);
          r.stop_time = TIMER_BITS'(sample_at + TIME_W'(stop_ticks));
          r.stop_time_valid = 1'b1;
          line_hi     = 1'b0;
          points_seen = '0;
          frame_bits  = '0;
          in_frame    = 1'b1;
        end else begin
          cur = {1'b0, req.timestamp};
          if (cur < prev_edge) cur[TIMER_BITS] = 1'b1;   // timer wrapped
          // points passed get the level before this edge; point 0 is the start bit
          while (points_seen < LAST_SAMPLE && cur > sample_at) begin
            if (points_seen != 0 && line_hi) frame_bits[points_seen - 1] = 1'b1;
            points_seen++;
            prev_edge = prev_edge + TIME_W'(bit_ticks);
            sample_at = sample_at + TIME_W'(bit_ticks);
          end
          line_hi = ~line_hi;
        end
      end
      MODE_STOP: begin
        if (in_frame) begin
          // bits not sampled yet take the present level
          first = (points_seen == 0) ? 0 : points_seen - 1;
          for (i = first; i < 8; i++) frame_bits[i] = line_hi;
          entry = {~line_hi, frame_bits};   // low stop bit: framing error
          in_frame    = 1'b0;
          points_seen = '0;
          if (fifo_level >= FIFO_DEPTH) begin
            overrun = 1'b1;
            bytes_dropped++;
          end else begin
            fifo_level++;
            wr_ptr++;
            rx_fifo[wr_ptr]     = entry;
            fifo_filled[wr_ptr] = 1'b1;
            bytes_stored++;
            if (fifo_level >= trig_level) r.trigger = 1'b1;
          end
        end
      end
      MODE_READ: begin
        // empty read hands back the last entry again
        if (fifo_level != 0) begin
          rd_ptr++;
          fifo_level--;
        end
        r.read_data          = rx_fifo[rd_ptr][7:0];
        r.read_framing_error = rx_fifo[rd_ptr][8];
        overrun = 1'b0;
      end
      default: ;
    endcase
    r.fifo_count = fifo_level;
    r.overflow   = overrun;
    r.busy_res   = in_frame;
    return r;
  endfunction

  function automatic out_item_t outcome(logic [15:0] stop_time, logic stv, logic [7:0] data,
                                        logic fe, logic [4:0] count, logic ovf, logic trig,
                                        logic busy);
    out_item_t r;
    r.stop_time          = stop_time;
    r.stop_time_valid    = stv;
    r.read_data          = data;
    r.read_framing_error = fe;
    r.fifo_count         = count;
    r.overflow           = ovf;
    r.trigger            = trig;
    r.busy_res           = busy;
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] mode, logic [15:0] ts, logic typed,
                                       out_item_t want);
    dir_row_t d;
    d.req.mode      = mode;
    d.req.timestamp = ts;
    d.typed         = typed;
    d.want          = want;
    return d;
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf("stop_time=%h stv=%b data=%h fe=%b count=%0d ovf=%b trig=%b busy=%b",
                     r.stop_time, r.stop_time_valid, r.read_data, r.read_framing_error,
                     r.fifo_count, r.overflow, r.trigger, r.busy_res);
  endfunction

  // An empty read returns the entry under the read pointer, which must have been written.
  function automatic bit read_allowed();
    return fifo_level != 0 || fifo_filled[rd_ptr];
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Called right after the previous acceptance edge, so valid
  // stays up without a dip when the next gap is zero.
  // ---------------------------------------------------------------------------
  task automatic send_req(logic [1:0] mode, logic [15:0] ts, logic typed, out_item_t want);
    in_item_t  req;
    out_item_t pred;
    int        gap;
    req.mode      = mode;
    req.timestamp = ts;
    if (tx_streak > 0) begin
      gap = 0;
      tx_streak--;
    end else if ($urandom_range(0, 49) == 0) begin
      gap = 0;
      tx_streak = $urandom_range(20, 80);
    end else begin
      gap = $urandom_range(0, 11);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = decode_event(req);
    pending_results.push_back(typed ? want : pred);
    sent++;
  endtask

  task automatic send_plain(logic [1:0] mode, logic [15:0] ts);
    send_req(mode, ts, 1'b0, '0);
  endtask

  task automatic send_read();
    if (read_allowed()) send_plain(MODE_READ, 16'($urandom));
    else send_plain(MODE_SPARE, 16'($urandom));
  endtask

  // Random event of any mode, timestamp anywhere.
  task automatic send_noise();
    logic [1:0] mode;
    mode = 2'($urandom_range(0, 3));
    if (mode == MODE_READ && !read_allowed()) mode = MODE_SPARE;
    send_plain(mode, 16'($urandom));
  endtask

  // One 8N1 frame: start edge, an edge at each level change with a little
  // jitter past the bit boundary, then the stop-sample match. With cut
  // allowed some frames end early and leave the receiver mid-frame.
  task automatic send_frame(bit allow_cut);
    int unsigned t0;
    int unsigned jit;
    logic [7:0]  data;
    logic        stop_hi;
    logic        prev_lvl;
    logic        lvl;
    t0       = $urandom_range(0, 65535);
    data     = 8'($urandom);
    stop_hi  = ($urandom_range(0, 7) != 0);
    prev_lvl = 1'b0;
    send_plain(MODE_EDGE, 16'(t0));
    for (int k = 1; k <= 9; k++) begin
      lvl = (k <= 8) ? data[k - 1] : stop_hi;
      if (lvl != prev_lvl) begin
        jit = $urandom_range(0, bit_ticks / 4);
        send_plain(MODE_EDGE, 16'(t0 + k * bit_ticks + jit));
        prev_lvl = lvl;
      end
      if (allow_cut && $urandom_range(0, 99) == 0) return;
    end
    if (!(allow_cut && $urandom_range(0, 19) == 0))
      send_plain(MODE_STOP, 16'($urandom));
  endtask

  // Frames without reads until the FIFO is full and bytes get dropped.
  task automatic fill_fifo();
    int n;
    n = FIFO_DEPTH + $urandom_range(1, 3);
    repeat (n) send_frame(1'b0);
  endtask

  task automatic random_phase(int quota);
    int stop_at;
    int pick;
    int n;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(1'b1);
      end else if (pick < 82) begin
        n = $urandom_range(1, 3);
        repeat (n) send_read();
      end else if (pick < 84) begin
        fill_fifo();
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_noise();
      end
    end
  endtask

  // Drop valid and let every outstanding request drain before touching registers.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_BIT_PERIOD:  bit_ticks  = val;
      CFG_STOP_OFFSET: stop_ticks = val;
      CFG_RX_TRIGGER:  trig_level = val[TRIG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] period, logic [15:0] offset, logic [4:0] trig);
    write_reg(CFG_BIT_PERIOD, period);
    write_reg(CFG_STOP_OFFSET, offset);
    write_reg(CFG_RX_TRIGGER, {11'd0, trig});
    cfg_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready stalls, plus a long hold-off on request from the
  // stimulus so the block backs up and stops taking requests.
  // ---------------------------------------------------------------------------
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", fmt_result(got));
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    if (got.stop_time !== want.stop_time || got.stop_time_valid !== want.stop_time_valid ||
        got.read_data !== want.read_data ||
        got.read_framing_error !== want.read_framing_error ||
        got.fifo_count !== want.fifo_count || got.overflow !== want.overflow ||
        got.trigger !== want.trigger || got.busy_res !== want.busy_res) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on result %0d", results_seen);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endtask

  initial begin
    int gap;
    int streak;
    streak = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
        holds_done++;
      end else if (streak > 0) begin
        gap = 0;
        streak--;
      end else if ($urandom_range(0, 49) == 0) begin
        gap = 0;
        streak = $urandom_range(20, 80);
      end else begin
        gap = $urandom_range(0, 11);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result(out_data);
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed rows at reset settings: 434 ticks per bit, stop 3906 after
    // the first sample, trigger at one entry.
    dir_tab[0]  = dir_row(MODE_STOP, 16'hFFFF, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab[1]  = dir_row(MODE_SPARE, 16'hFFFF, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 0));
    // start at 0: sample at 217, stop compare at 217 + 3906
    dir_tab[2]  = dir_row(MODE_EDGE, 16'h0000, 1'b1, outcome(16'd4123, 1, 0, 0, 0, 0, 0, 1));
    // no edges: every bit low, low stop bit, framing error stored
    dir_tab[3]  = dir_row(MODE_STOP, 16'h0000, 1'b1, outcome(0, 0, 0, 0, 1, 0, 1, 0));
    dir_tab[4]  = dir_row(MODE_READ, 16'h0000, 1'b1, outcome(0, 0, 8'h00, 1, 0, 0, 0, 0));
    // empty read repeats the last entry
    dir_tab[5]  = dir_row(MODE_READ, 16'hFFFF, 1'b1, outcome(0, 0, 8'h00, 1, 0, 0, 0, 0));
    // start at the top of the timer: stop compare wraps
    dir_tab[6]  = dir_row(MODE_EDGE, 16'hFFFF, 1'b1, outcome(16'h101A, 1, 0, 0, 0, 0, 0, 1));
    dir_tab[7]  = dir_row(MODE_EDGE, 16'h0005, 1'b0, '0);   // wrapped edge, before any sample
    dir_tab[8]  = dir_row(MODE_EDGE, 16'h8000, 1'b0, '0);   // runs past all nine points
    dir_tab[9]  = dir_row(MODE_EDGE, 16'h8100, 1'b0, '0);   // sampling already finished
    dir_tab[10] = dir_row(MODE_STOP, 16'h1234, 1'b1, outcome(0, 0, 0, 0, 1, 0, 1, 0));
    dir_tab[11] = dir_row(MODE_READ, 16'h0000, 1'b1, outcome(0, 0, 8'hFF, 0, 0, 0, 0, 0));
    // clean frame carrying 0x55: every bit toggles the line
    dir_tab[12] = dir_row(MODE_EDGE, 16'h1000, 1'b0, '0);
    for (int k = 1; k <= 9; k++)
      dir_tab[12 + k] = dir_row(MODE_EDGE, 16'(16'h1000 + k * 434 + 10), 1'b0, '0);
    dir_tab[22] = dir_row(MODE_STOP, 16'h0000, 1'b1, outcome(0, 0, 0, 0, 1, 0, 1, 0));
    dir_tab[23] = dir_row(MODE_READ, 16'h0000, 1'b1, outcome(0, 0, 8'h55, 0, 0, 0, 0, 0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      send_req(dir_tab[r].req.mode, dir_tab[r].req.timestamp, dir_tab[r].typed,
               dir_tab[r].want);

    // full FIFO, dropped bytes, then a read clears the sticky flag
    fill_fifo();
    repeat (FIFO_DEPTH + 2) send_read();
    random_phase(PHASE_ITEMS);

    // Register settings: extremes of period and offset, trigger at 0, 1,
    // 16 and in between, and one random setting.
    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: set_config(16'd4, 16'd4, 5'd16);
        1: set_config(16'd65535, 16'd65535, 5'd16);
        2: set_config(16'd4, 16'd65535, 5'd1);
        3: set_config(16'd65535, 16'd4, 5'd0);
        4: set_config(16'd16, 16'd150, 5'd8);
        5: set_config(16'd100, 16'd900, 5'd4);
        default: set_config(16'($urandom_range(4, 2000)), 16'($urandom_range(4, 20000)),
                            5'($urandom_range(1, 16)));
      endcase
      if (p == 1 || p == 4) hold_off_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain();
    $display("covered %0d requests over %0d register settings, %0d results checked",
             sent, cfg_settings, results_seen);
    $display("bytes stored %0d, bytes dropped on full FIFO %0d, long output stalls %0d",
             bytes_stored, bytes_dropped, holds_done);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
